// File: sv/indexed_deque_core_defines.svh
// Assertion macros shared by the indexed deque RTL.
`ifndef INDEXED_DEQUE_CORE_DEFINES_SVH
`define INDEXED_DEQUE_CORE_DEFINES_SVH

// Checked on every clock edge while reset is released.
`define IDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/idq_pkg.sv
package idq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int POS_W      = 5;
    localparam int XW         = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        OP_ENQUEUE   = 3'd0,
        OP_DEQUEUE   = 3'd1,
        OP_PEEK      = 3'd2,
        OP_READ_AT   = 3'd3,
        OP_REMOVE_AT = 3'd4,
        OP_POP_BACK  = 3'd5,
        OP_INSERT_AT = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// File: sv/indexed_deque_core.sv
// Indexed deque: one operation per accepted word, one result word per operation.
// Each word goes through S_FETCH (store read), then S_SHIFT and S_FLUSH while entries
// move, one per cycle, then S_PUT to write an enqueued or inserted word, then S_DONE.
// Peek, read_at, pop_back, clear and refused words go from S_FETCH straight to S_DONE.
// A word is taken only in S_IDLE; a stalled result holds off the next word.
// Reset (synchronous, active low) empties the queue and drops any pending result.
`include "indexed_deque_core_defines.svh"

module indexed_deque_core
    import idq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_data_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_data_out,
    output logic [4:0]  o_count,
    output logic [1:0]  o_status
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_SHIFT = 6'b000100,
        S_FLUSH = 6'b001000,
        S_PUT   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_newcnt, n_newcnt;
    t_op                   r_op;
    t_status               r_status, n_status;
    logic [AW-1:0]         r_ep, n_ep;
    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] r_dout;
    logic [AW-1:0]         r_src, r_end, r_wa;
    logic                  r_down, r_pend;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  wr_en;

    logic                  accept, out_free;
    t_op                   in_op;
    logic [XW-1:0]         in_pos_x, cnt_x;
    logic                  is_rm, is_ins, is_rd;
    logic [CW-1:0]         ep_x;
    logic                  res_full, res_err, in_move;

    assign accept   = i_valid && r_state == S_IDLE;
    assign o_stall  = r_state != S_IDLE;
    assign out_free = !o_valid || !i_stall;
    assign in_op    = t_op'(i_op);
    assign in_pos_x = XW'(i_position);
    assign cnt_x    = XW'(r_count);

    // Decode of the incoming word against the current occupancy.
    always_comb begin
        n_status = ST_OK;
        n_ep     = AW'(i_position);
        n_newcnt = r_count;
        case (in_op)
            OP_ENQUEUE: begin
                n_ep = AW'(r_count);
                if (r_count == CW'(DEPTH)) n_status = ST_FULL;
                else                       n_newcnt = r_count + CW'(1);
            end
            OP_DEQUEUE, OP_PEEK, OP_POP_BACK: begin
                n_ep = (in_op == OP_POP_BACK) ? AW'(r_count - CW'(1)) : '0;
                if (r_count == '0) n_status = ST_EMPTY;
                else if (in_op != OP_PEEK) n_newcnt = r_count - CW'(1);
            end
            OP_READ_AT, OP_REMOVE_AT: begin
                if (in_pos_x >= cnt_x) n_status = ST_BAD_INDEX;
                else if (in_op == OP_REMOVE_AT) n_newcnt = r_count - CW'(1);
            end
            OP_INSERT_AT: begin
                if (r_count == CW'(DEPTH)) n_status = ST_FULL;
                else if (in_pos_x > cnt_x) n_status = ST_BAD_INDEX;
                else n_newcnt = r_count + CW'(1);
            end
            OP_CLEAR: n_newcnt = '0;
            default: n_status = ST_OK;
        endcase
    end

    assign is_rm  = r_op == OP_DEQUEUE || r_op == OP_REMOVE_AT;
    assign is_ins = r_op == OP_ENQUEUE || r_op == OP_INSERT_AT;
    assign is_rd  = r_op == OP_DEQUEUE || r_op == OP_PEEK || r_op == OP_READ_AT
                 || r_op == OP_REMOVE_AT || r_op == OP_POP_BACK;
    assign ep_x   = CW'(r_ep);

    // Store port control: the read address walks with the shift source, the
    // write lands in the following cycle, one place up or down.
    always_comb begin
        rd_addr = (r_state == S_IDLE) ? n_ep : r_src;
        wr_en   = 1'b0;
        wr_addr = r_wa;
        wr_data = r_rdata;
        if (r_pend && (r_state == S_SHIFT || r_state == S_FLUSH)) begin
            wr_en = 1'b1;
        end else if (r_state == S_PUT) begin
            wr_en   = 1'b1;
            wr_addr = r_ep;
            wr_data = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_FETCH;
            S_FETCH: begin
                n_state = S_DONE;
                if (r_status == ST_OK && is_rm && (ep_x + CW'(1)) < r_count)
                    n_state = S_SHIFT;
                else if (r_status == ST_OK && is_ins && r_count > ep_x)
                    n_state = S_SHIFT;
                else if (r_status == ST_OK && is_ins)
                    n_state = S_PUT;
            end
            S_SHIFT: if (r_src == r_end) n_state = S_FLUSH;
            S_FLUSH: n_state = is_ins ? S_PUT : S_DONE;
            S_PUT:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= r_state == S_SHIFT;
            if (r_state == S_DONE && out_free) begin
                o_valid <= 1'b1;
                r_count <= r_newcnt;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= in_op;
            r_status <= n_status;
            r_ep     <= n_ep;
            r_newcnt <= n_newcnt;
            r_word   <= i_data_in[DATA_WIDTH-1:0];
        end
        if (r_state == S_FETCH) begin
            r_dout <= (r_status == ST_OK && is_rd) ? r_rdata : '0;
            r_down <= is_ins;
            if (is_ins) begin
                r_src <= AW'(r_count - CW'(1));
                r_end <= r_ep;
            end else begin
                r_src <= r_ep + AW'(1);
                r_end <= AW'(r_count - CW'(1));
            end
        end
        if (r_state == S_SHIFT) begin
            r_wa  <= r_down ? r_src + AW'(1) : r_src - AW'(1);
            r_src <= r_down ? r_src - AW'(1) : r_src + AW'(1);
        end
        if (r_state == S_DONE && out_free) begin
            o_data_out <= 32'(r_dout);
            o_count    <= 5'(r_newcnt);
            o_status   <= r_status;
        end
    end

    assign res_full = o_valid && o_status == ST_FULL;
    assign res_err  = o_valid && o_status != ST_OK;
    assign in_move  = r_state == S_SHIFT || r_state == S_FLUSH;

    `IDQ_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "occupancy above depth")
    `IDQ_ASSERT(a_accept_fetch, accept |=> r_state == S_FETCH, "accept did not start fetch")
    `IDQ_ASSERT(a_full_count, res_full |-> o_count == 5'(DEPTH), "full status below depth")
    `IDQ_ASSERT(a_err_zero, res_err |-> o_data_out == '0, "error result carries data")
    `IDQ_ASSERT_ALWAYS(a_pend_place, (i_rst_n && r_pend) |-> in_move, "move outside shift")

endmodule
